// ===== src/utl_pkg.sv =====
// types and constants shared by the utc to local date and time converter
`default_nettype none
package utl_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned LYEAR_W  = 15;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINSEC_W = 6;
    localparam int unsigned OFFSET_W = 5;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;

    localparam logic signed [6:0] HOURS_PER_DAY = 7'sd24;

    typedef struct packed {
        logic [YEAR_W-1:0]   utc_year;
        logic [MONTH_W-1:0]  utc_month;
        logic [DAY_W-1:0]    utc_day;
        logic [HOUR_W-1:0]   utc_hour;
        logic [MINSEC_W-1:0] utc_minute;
        logic [MINSEC_W-1:0] utc_second;
        logic                date_valid;
        logic                time_valid;
    } t_utc_item;

    typedef struct packed {
        logic signed [LYEAR_W-1:0] local_year;
        logic [MONTH_W-1:0]        local_month;
        logic [DAY_W-1:0]          local_day;
        logic [HOUR_W-1:0]         local_hour;
        logic [MINSEC_W-1:0]       local_minute;
        logic [MINSEC_W-1:0]       local_second;
        logic                      local_date_ok;
        logic                      local_time_ok;
    } t_local_item;

endpackage
`default_nettype wire

// ===== src/utl_month_days.sv =====
// month length with gregorian leap years, odd months count as thirty days
`default_nettype none
module utl_month_days
    import utl_pkg::*;
(
    input  wire logic [YEAR_W-1:0]  i_year,
    input  wire logic [MONTH_W-1:0] i_month,
    output logic      [DAY_W-1:0]   o_days
);

    // floor(y / 25) by reciprocal, exact for all 14 bit years
    localparam logic [12:0] Recip25 = 13'd5243;
    localparam int unsigned Shift25 = 17;

    logic [YEAR_W+12:0] prod;
    logic [9:0]         quot;
    logic [YEAR_W:0]    back;
    logic               div25;
    logic               leap;

    always_comb begin
        prod  = {13'd0, i_year} * {{YEAR_W{1'b0}}, Recip25};
        quot  = prod[Shift25+9:Shift25];
        back  = {1'b0, quot, 4'd0} + {2'b0, quot, 3'd0} + {5'd0, quot};
        div25 = (back == {1'b0, i_year});
        // by 4, and not by 100 unless by 400
        leap  = (i_year[1:0] == 2'd0) && (!div25 || (i_year[3:0] == 4'd0));
    end

    always_comb begin
        unique case (i_month) inside
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                o_days = DAYS_31;
            MON_FEB:
                o_days = leap ? DAYS_29 : DAYS_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:
                o_days = DAYS_30;
            default:
                o_days = DAYS_30;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/utl_convert.sv =====
// hour offset with one day step forward or back and validity masking
`default_nettype none
module utl_convert
    import utl_pkg::*;
(
    input  wire t_utc_item                  i_item,
    input  wire logic signed [OFFSET_W-1:0] i_offset,
    output t_local_item                     o_item
);

    logic signed [6:0]     hour_sum;
    logic signed [6:0]     hour_adj;
    logic                  step_fwd;
    logic                  step_back;
    logic [MONTH_W-1:0]    prev_month;
    logic                  prev_year;
    logic [MONTH_W-1:0]    len_month;
    logic [DAY_W-1:0]      month_len;
    logic [DAY_W:0]        day_inc;
    logic [MONTH_W-1:0]    new_month;
    logic [DAY_W-1:0]      new_day;
    logic [LYEAR_W-1:0]    new_year;
    logic [LYEAR_W-1:0]    year_ext;

    utl_month_days u_month_days (
        .i_year  (i_item.utc_year),
        .i_month (len_month),
        .o_days  (month_len)
    );

    always_comb begin
        hour_sum  = $signed({2'b00, i_item.utc_hour}) + 7'(i_offset);
        step_fwd  = (hour_sum >= HOURS_PER_DAY);
        step_back = (hour_sum < 7'sd0);
        if (step_fwd) begin
            hour_adj = hour_sum - HOURS_PER_DAY;
        end else if (step_back) begin
            hour_adj = hour_sum + HOURS_PER_DAY;
        end else begin
            hour_adj = hour_sum;
        end

        prev_year = (i_item.utc_month <= MON_JAN);
        if (prev_year) begin
            prev_month = MON_DEC;
        end else begin
            prev_month = i_item.utc_month - 4'd1;
        end
        // going back into a new year lands on december, so the year never matters there
        len_month = step_back ? prev_month : i_item.utc_month;

        year_ext  = {1'b0, i_item.utc_year};
        day_inc   = {1'b0, i_item.utc_day} + 6'd1;
        new_year  = year_ext;
        new_month = i_item.utc_month;
        new_day   = i_item.utc_day;
        if (step_fwd) begin
            if (day_inc > {1'b0, month_len}) begin
                new_day = 5'd1;
                if (i_item.utc_month >= MON_DEC) begin
                    new_month = MON_JAN;
                    new_year  = year_ext + 15'd1;
                end else begin
                    new_month = i_item.utc_month + 4'd1;
                end
            end else begin
                new_day = day_inc[DAY_W-1:0];
            end
        end else if (step_back) begin
            if (i_item.utc_day <= 5'd1) begin
                new_month = prev_month;
                new_day   = month_len;
                if (prev_year) begin
                    new_year = year_ext - 15'd1;
                end
            end else begin
                new_day = i_item.utc_day - 5'd1;
            end
        end

        o_item = '0;
        if (i_item.time_valid) begin
            o_item.local_hour    = hour_adj[HOUR_W-1:0];
            o_item.local_minute  = i_item.utc_minute;
            o_item.local_second  = i_item.utc_second;
            o_item.local_time_ok = 1'b1;
            if (i_item.date_valid) begin
                o_item.local_year    = $signed(new_year);
                o_item.local_month   = new_month;
                o_item.local_day     = new_day;
                o_item.local_date_ok = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/utc_to_local_date_time.sv =====
// top level: utc to local date and time converter
// the accepted item passes the input register and then the result register before it reaches the outputs
// throughput: one item per cycle, busy is never raised
// the path from input register to result register holds one calendar step
// reset clears the offset register to zero and drops any item in flight
`default_nettype none
module utc_to_local_date_time
    import utl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire t_utc_item           i_utc,
    output logic                     o_busy,
    input  wire logic                i_cfg_we,
    input  wire logic [OFFSET_W-1:0] i_cfg_wdata,
    output logic                     o_valid,
    output t_local_item              o_local
);

    logic signed [OFFSET_W-1:0] r_offset;
    logic                       r_in_valid;
    t_utc_item                  r_in_item;
    logic                       r_out_valid;
    t_local_item                r_out_item;
    t_local_item                n_out_item;
    logic                       n_in_valid;

    assign o_busy     = 1'b0;
    assign n_in_valid = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= $signed(i_cfg_wdata);
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_in_item <= i_utc;
        end
        if (r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

    utl_convert u_convert (
        .i_item   (r_in_item),
        .i_offset (r_offset),
        .o_item   (n_out_item)
    );

    assign o_valid = r_out_valid;
    assign o_local = r_out_item;

endmodule
`default_nettype wire

// ===== src/utl_checker.sv =====
// port checker for the utc to local converter, bound to the top level
`default_nettype none
module utl_checker
    import utl_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_start,
    input wire logic                o_busy,
    input wire logic                o_valid,
    input wire t_local_item         o_local
);

    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("item accepted without a result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without an accepted item");

    a_date_needs_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_local.local_date_ok) |-> o_local.local_time_ok)
        else $error("date marked good without a good time");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_local.local_time_ok) |->
            (o_local.local_hour == '0) && (o_local.local_minute == '0) &&
            (o_local.local_second == '0) && (o_local.local_year == '0))
        else $error("invalid item carries non-zero fields");

endmodule

bind utc_to_local_date_time utl_checker u_utl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_local (o_local)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the utc to local date and time converter: directed and random items checked against a predictor
`timescale 1ns / 100ps
module tb_top;
    import utl_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef enum logic [1:0] {STEP_ITEM, STEP_OFFSET, STEP_DRAIN} t_step_kind;

    typedef struct {
        t_step_kind                  kind;
        t_utc_item                   utc;
        logic signed [OFFSET_W-1:0]  offset;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    t_utc_item             i_utc = '0;
    logic                  i_cfg_we = 1'b0;
    logic [OFFSET_W-1:0]   i_cfg_wdata = '0;
    logic                  o_busy;
    logic                  o_valid;
    t_local_item           o_local;

    t_step                 pending_steps[$];
    t_local_item           local_expected[$];
    int                    outstanding = 0;
    int                    mismatch_count = 0;
    int                    idle_cycles = 0;
    int                    burst_left = 10;
    int                    gap_left = 0;
    logic signed [OFFSET_W-1:0] offset_now = '0;

    utc_to_local_date_time dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_utc       (i_utc),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_local     (o_local)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int month_len(int y, int m);
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: return DAYS_31;
            MON_FEB: begin
                if (y >= 0 && ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)))
                    return DAYS_29;
                return DAYS_28;
            end
            default: return DAYS_30;
        endcase
    endfunction

    function automatic t_local_item predict_local(t_utc_item u, logic signed [OFFSET_W-1:0] off);
        t_local_item r;
        int y;
        int m;
        int d;
        int h;
        y = u.utc_year;
        m = u.utc_month;
        d = u.utc_day;
        h = int'(u.utc_hour) + int'(off);
        if (h >= HOURS_PER_DAY) begin
            h -= HOURS_PER_DAY;
            d++;
            if (d > month_len(y, m)) begin
                d = 1;
                m++;
                if (m > int'(MON_DEC)) begin
                    m = MON_JAN;
                    y++;
                end
            end
        end else if (h < 0) begin
            h += HOURS_PER_DAY;
            d--;
            if (d < 1) begin
                m--;
                if (m < int'(MON_JAN)) begin
                    m = MON_DEC;
                    y--;
                end
                d = month_len(y, m);
            end
        end
        r = '0;
        if (u.time_valid) begin
            r.local_hour = 5'(h);
            r.local_minute = u.utc_minute;
            r.local_second = u.utc_second;
            r.local_time_ok = 1'b1;
            if (u.date_valid) begin
                r.local_year = 15'(y);
                r.local_month = 4'(m);
                r.local_day = 5'(d);
                r.local_date_ok = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_utc_item make_utc(int y, int m, int d, int h, int mi, int s,
                                           bit dv, bit tv);
        t_utc_item u;
        u.utc_year = 14'(y);
        u.utc_month = 4'(m);
        u.utc_day = 5'(d);
        u.utc_hour = 5'(h);
        u.utc_minute = 6'(mi);
        u.utc_second = 6'(s);
        u.date_valid = dv;
        u.time_valid = tv;
        return u;
    endfunction

    function automatic t_utc_item random_utc(int off);
        t_utc_item u;
        int r;
        r = $urandom_range(99);
        if (r < 3)
            u.utc_year = 14'($urandom);
        else if (r < 25)
            u.utc_year = 14'($urandom_range(99) * 100);
        else
            u.utc_year = 14'($urandom_range(9999));
        u.utc_month = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom);
        r = $urandom_range(99);
        if (r < 40)
            u.utc_day = 5'($urandom_range(31, 27));
        else if (r < 70)
            u.utc_day = 5'($urandom_range(2));
        else
            u.utc_day = 5'($urandom);
        r = $urandom_range(99);
        if (r < 65 && off > 0)
            u.utc_hour = 5'($urandom_range(23, 24 - off));
        else if (r < 65 && off < 0)
            u.utc_hour = 5'($urandom_range(-off - 1, 0));
        else
            u.utc_hour = 5'($urandom_range(23));
        u.utc_minute = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
        u.utc_second = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
        u.date_valid = ($urandom_range(9) != 0);
        u.time_valid = ($urandom_range(9) != 0);
        return u;
    endfunction

    task automatic push_item(t_utc_item u);
        t_step s;
        s.kind = STEP_ITEM;
        s.utc = u;
        s.offset = '0;
        pending_steps.push_back(s);
    endtask

    task automatic push_offset(int v);
        t_step s;
        s.kind = STEP_OFFSET;
        s.utc = '0;
        s.offset = 5'(v);
        pending_steps.push_back(s);
    endtask

    task automatic push_drain();
        t_step s;
        s.kind = STEP_DRAIN;
        s.utc = '0;
        s.offset = '0;
        pending_steps.push_back(s);
    endtask

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [15:0] seen, logic [15:0] want);
        if (seen !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, seen, want));
    endtask

    // driver: bursts of items, offset writes only once the converter has drained
    always @(posedge i_clk) begin : utc_driver
        logic sent;
        t_step step;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            sent = i_start && !o_busy;
            if (i_start && !sent) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                i_start <= 1'b0;
                i_cfg_we <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_steps.size() == 0) begin
                i_start <= 1'b0;
                i_cfg_we <= 1'b0;
            end else if (pending_steps[0].kind == STEP_ITEM) begin
                step = pending_steps.pop_front();
                i_start <= 1'b1;
                i_utc <= step.utc;
                i_cfg_we <= 1'b0;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(9) == 0) ? $urandom_range(300, 100)
                                                           : $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else if (outstanding != 0 || sent) begin
                i_start <= 1'b0;
                i_cfg_we <= 1'b0;
            end else begin
                step = pending_steps.pop_front();
                i_start <= 1'b0;
                if (step.kind == STEP_OFFSET) begin
                    i_cfg_we <= 1'b1;
                    i_cfg_wdata <= step.offset;
                end else begin
                    i_cfg_we <= 1'b0;
                end
            end
        end
    end

    // monitor: predicts on acceptance, checks each result strobe
    always @(posedge i_clk) begin : local_monitor
        logic took;
        logic seen;
        t_local_item want;
        if (!i_rst_n) begin
            offset_now <= '0;
            outstanding <= 0;
            idle_cycles <= 0;
        end else begin
            took = i_start && !o_busy;
            seen = (o_valid === 1'b1);
            if ($isunknown(o_valid))
                report_mismatch("result strobe unknown");
            if (seen) begin
                if (local_expected.size() == 0) begin
                    report_mismatch("result with no item pending");
                end else begin
                    want = local_expected.pop_front();
                    check_field("local_year", o_local.local_year, want.local_year);
                    check_field("local_month", o_local.local_month, want.local_month);
                    check_field("local_day", o_local.local_day, want.local_day);
                    check_field("local_hour", o_local.local_hour, want.local_hour);
                    check_field("local_minute", o_local.local_minute, want.local_minute);
                    check_field("local_second", o_local.local_second, want.local_second);
                    check_field("local_date_ok", o_local.local_date_ok, want.local_date_ok);
                    check_field("local_time_ok", o_local.local_time_ok, want.local_time_ok);
                end
            end
            if (took)
                local_expected.push_back(predict_local(i_utc, offset_now));
            if (i_cfg_we)
                offset_now <= i_cfg_wdata;
            outstanding <= outstanding + (took ? 1 : 0) - ((seen && local_expected.size() + (took ? 0 : 1) > 0) ? 1 : 0);
            if (took || seen) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("utc_to_local_date_time regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int off;

        // no offset: field extremes, out of range minute and second, invalid parts
        push_offset(0);
        push_item(make_utc(0, 0, 0, 0, 0, 0, 1, 1));
        push_item(make_utc(9999, 12, 31, 23, 59, 59, 1, 1));
        push_item(make_utc(16383, 15, 31, 23, 63, 63, 1, 1));
        push_item(make_utc(2024, 6, 15, 12, 60, 61, 0, 1));
        push_item(make_utc(2024, 6, 15, 12, 30, 30, 1, 0));

        // largest offset: forward steps across month and year ends, odd months and days
        push_offset(14);
        push_item(make_utc(2023, 12, 31, 10, 0, 0, 1, 1));
        push_item(make_utc(2024, 2, 28, 12, 1, 2, 1, 1));
        push_item(make_utc(2023, 2, 28, 12, 3, 4, 1, 1));
        push_item(make_utc(2000, 2, 29, 23, 5, 6, 1, 1));
        push_item(make_utc(1900, 2, 28, 20, 7, 8, 1, 1));
        push_item(make_utc(2024, 13, 30, 15, 9, 10, 1, 1));
        push_item(make_utc(2024, 0, 30, 15, 11, 12, 1, 1));
        push_item(make_utc(2024, 15, 30, 15, 13, 14, 1, 1));
        push_item(make_utc(2024, 4, 31, 10, 15, 16, 1, 1));
        push_item(make_utc(16383, 12, 31, 10, 17, 18, 1, 1));
        push_item(make_utc(2024, 5, 0, 20, 19, 20, 1, 1));

        // smallest offset: backward steps, year zero, odd months and days, invalid parts
        push_offset(-12);
        push_item(make_utc(2024, 3, 1, 5, 21, 22, 1, 1));
        push_item(make_utc(2023, 3, 1, 5, 23, 24, 1, 1));
        push_item(make_utc(0, 1, 1, 0, 25, 26, 1, 1));
        push_item(make_utc(2024, 0, 1, 3, 27, 28, 1, 1));
        push_item(make_utc(2024, 13, 0, 2, 29, 30, 1, 1));
        push_item(make_utc(2024, 14, 1, 0, 31, 32, 1, 1));
        push_item(make_utc(2100, 3, 0, 0, 33, 34, 1, 1));
        push_item(make_utc(2024, 1, 1, 11, 35, 36, 1, 0));
        push_item(make_utc(2024, 1, 1, 11, 37, 38, 0, 1));

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0)
                off = -12;
            else if (ph == 1)
                off = 14;
            else if (ph == 11)
                off = 0;
            else
                off = $urandom_range(26) - 12;
            push_offset(off);
            for (int i = 0; i < 150; i++) begin
                if (i == 75 && ph % 3 == 0)
                    push_drain();
                push_item(random_utc(off));
            end
        end

        while (pending_steps.size() != 0 || i_start || outstanding != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (local_expected.size() != 0)
            report_mismatch("items left without a result");
        if (mismatch_count == 0) begin
            $display("utc_to_local_date_time regression: pass");
        end else begin
            $display("utc_to_local_date_time regression: fail");
        end
        $finish;
    end

endmodule
